// ===== hw/rtl/fspe_pkg.sv =====
// Package: shared constants and request codes for the shortest path engine.
`timescale 1ns / 1ps
package fspe_pkg;
  localparam int unsigned NodeW = 10;
  localparam int unsigned LenW  = 20;
  localparam int unsigned AgeW  = 16;
  localparam int unsigned DistW = 32;
  localparam logic [DistW-1:0] InfDist = 32'h3f3f3f3f;
  localparam logic [NodeW-1:0] StartNode = 10'd1;
  localparam logic [NodeW-1:0] TargetReset = 10'd1;
  localparam logic ReqLoad = 1'b0;
  localparam logic ReqRun  = 1'b1;
endpackage

// ===== hw/rtl/fspe_req_if.sv =====
// Interface: request channel (valid/ready with load or run payload).
`timescale 1ns / 1ps
interface fspe_req_if;
  logic valid;
  logic ready;
  logic req_type;
  logic [fspe_pkg::NodeW-1:0] src_node;
  logic [fspe_pkg::NodeW-1:0] dst_node;
  logic [fspe_pkg::LenW-1:0] edge_length;
  logic [fspe_pkg::AgeW-1:0] edge_age;
  logic [fspe_pkg::AgeW-1:0] age_limit;
  modport source (output valid, req_type, src_node, dst_node, edge_length, edge_age,
                  age_limit, input ready);
  modport sink (input valid, req_type, src_node, dst_node, edge_length, edge_age,
                age_limit, output ready);
endinterface

// ===== hw/rtl/fspe_res_if.sv =====
// Interface: result channel carrying the target distance.
`timescale 1ns / 1ps
interface fspe_res_if;
  logic valid;
  logic ready;
  logic [fspe_pkg::DistW-1:0] target_distance;
  modport source (output valid, target_distance, input ready);
  modport sink (input valid, target_distance, output ready);
endinterface

// ===== hw/rtl/filtered_shortest_path_engine.sv =====
// Top level: edge store, SPFA sequencer with a shared saturating add/compare unit.
//
// Usage: req (sink) takes items. A load item (req_type 0): the accept cycle
// writes the edge fields and reads the source list head, the next cycle
// links the edge in front of that list. A run item (req_type 1) clears the
// distance and in-queue tables, one entry a cycle, then walks the work
// queue: each node pop goes through queue read, pop and head read, each
// scanned edge through edge read, shared add/compare and write back, and an
// empty queue ends the walk after the queue read and pop. The walk length
// is set by how many relaxations the graph needs; the shared adder/compare
// is the bottleneck. After the walk the target distance is read and
// registered in an output register on res (source); the block takes its
// next request only after that result is taken, so a stalled receiver
// simply holds the block. Loads produce no result. target_node is set
// through cfg_we_i/cfg_data_i; the user must write it only while idle,
// and the block itself does not enforce this. Reset: edge count 0,
// target_node 1, then a pass that empties every list head with req.ready
// low. Edge store contents are undefined until written.
`timescale 1ns / 1ps
module filtered_shortest_path_engine #(
  parameter int unsigned NODES = 1024,
  parameter int unsigned EDGES = 4096
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [fspe_pkg::NodeW-1:0] cfg_data_i,
  fspe_req_if.sink req,
  fspe_res_if.source res
);
  localparam int unsigned NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned EW = $clog2(EDGES + 1);
  localparam int unsigned CW = $clog2(NODES + 1);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_LOAD, S_CLEAR, S_QRD, S_POP, S_HEAD, S_EREAD, S_EVAL, S_UPD,
    S_TREAD, S_TOUT, S_OUT
  } state_e;

  state_e state_q;
  logic [fspe_pkg::NodeW-1:0] target_q;
  logic [EW-1:0] ecount_q;

  // Memories
  logic [EW-1:0] head_mem [NODES];
  logic [EW-1:0] next_mem [EDGES+1];
  logic [fspe_pkg::NodeW-1:0] dest_mem [EDGES+1];
  logic [fspe_pkg::LenW-1:0] wgt_mem [EDGES+1];
  logic [fspe_pkg::AgeW-1:0] year_mem [EDGES+1];
  logic [fspe_pkg::DistW-1:0] dist_mem [NODES];
  logic inq_mem [NODES];
  logic [NW-1:0] queue_mem [NODES];

  logic [NW-1:0] rd_q, wr_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] x_q;
  logic [fspe_pkg::DistW-1:0] dx_q, cand_q;
  logic [EW-1:0] e_q;
  logic [fspe_pkg::NodeW-1:0] y_q;
  logic [fspe_pkg::LenW-1:0] w_q;
  logic [fspe_pkg::AgeW-1:0] yr_q, lim_q;
  logic [NW-1:0] clr_q;
  logic [NW-1:0] src_q;
  logic [EW-1:0] head_rd_q;
  logic [fspe_pkg::DistW-1:0] res_q;

  // Shared saturating adder
  logic [fspe_pkg::DistW-1:0] wsel;
  logic [fspe_pkg::DistW:0] sum;
  logic [fspe_pkg::DistW-1:0] sat;
  assign wsel = (yr_q <= lim_q) ? fspe_pkg::InfDist
                                : {{(fspe_pkg::DistW-fspe_pkg::LenW){1'b0}}, w_q};
  assign sum = {1'b0, dx_q} + {1'b0, wsel};
  assign sat = sum[fspe_pkg::DistW] ? {fspe_pkg::DistW{1'b1}} : sum[fspe_pkg::DistW-1:0];

  logic src_ok, dst_ok, tgt_ok, y_ok, load_ok;
  assign src_ok = {22'd0, req.src_node} < 32'(NODES);
  assign dst_ok = {22'd0, req.dst_node} < 32'(NODES);
  assign tgt_ok = {22'd0, target_q} < 32'(NODES);
  assign y_ok   = {22'd0, y_q} < 32'(NODES);
  assign load_ok = src_ok && dst_ok && (32'(ecount_q) < 32'(EDGES));

  logic [NW-1:0] src_idx, y_idx, t_idx;
  assign src_idx = NW'(req.src_node);
  assign y_idx   = NW'(y_q);
  assign t_idx   = NW'(target_q);

  logic [EW-1:0] ecount_inc;
  assign ecount_inc = ecount_q + EW'(1);

  // Read addresses: the popped node is taken straight from the queue read
  logic [NW-1:0] x_addr, head_addr;
  assign x_addr    = (state_q == S_POP) ? q_rd : x_q;
  assign head_addr = (state_q == S_IDLE) ? src_idx : x_addr;

  // Relaxation decision, valid in S_UPD
  logic [fspe_pkg::DistW-1:0] dist_rd;
  logic inq_rd;
  logic relax_ok, push_ok;
  assign relax_ok = y_ok && (cand_q < dist_rd);
  assign push_ok  = relax_ok && !inq_rd && (32'(cnt_q) < 32'(NODES));

  assign req.ready = (state_q == S_IDLE);
  assign res.valid = (state_q == S_OUT);
  assign res.target_distance = res_q;

  // Edge store writes: head clear after reset, edge fields, then the list link
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_INIT: head_mem[clr_q] <= '0;
      S_IDLE: begin
        if (req.valid && req.ready && req.req_type == fspe_pkg::ReqLoad && load_ok) begin
          dest_mem[ecount_inc] <= req.dst_node;
          wgt_mem[ecount_inc]  <= req.edge_length;
          year_mem[ecount_inc] <= req.edge_age;
        end
      end
      S_LOAD: begin
        next_mem[ecount_q] <= head_rd_q;
        head_mem[src_q]    <= ecount_q;
      end
      default: ;
    endcase
  end

  // Registered edge and head reads
  logic [EW-1:0] nx_rd;
  always_ff @(posedge clk_i) begin
    head_rd_q <= head_mem[head_addr];
    nx_rd     <= next_mem[e_q];
    y_q       <= dest_mem[e_q];
    w_q       <= wgt_mem[e_q];
    yr_q      <= year_mem[e_q];
  end

  // Distance table, in-queue flags and queue memories
  logic [NW-1:0] q_rd;
  always_ff @(posedge clk_i) begin
    q_rd   <= queue_mem[rd_q];
    inq_rd <= inq_mem[y_idx];
    unique case (state_q)
      S_CLEAR: begin
        dist_mem[clr_q] <= (clr_q == NW'(fspe_pkg::StartNode)) ? '0 : fspe_pkg::InfDist;
        inq_mem[clr_q]  <= (clr_q == NW'(fspe_pkg::StartNode));
      end
      S_POP: if (cnt_q != '0) inq_mem[q_rd] <= 1'b0;
      S_UPD: begin
        if (relax_ok) dist_mem[y_idx] <= cand_q;
        if (push_ok) inq_mem[y_idx] <= 1'b1;
      end
      default: ;
    endcase
    dist_rd <= (state_q == S_TREAD) ? dist_mem[t_idx]
             : (state_q == S_EVAL) ? dist_mem[y_idx] : dist_mem[x_addr];
    if (state_q == S_CLEAR && clr_q == NW'(0)) queue_mem[0] <= NW'(fspe_pkg::StartNode);
    else if (state_q == S_UPD && push_ok)
      queue_mem[wr_q] <= y_idx;
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      target_q <= fspe_pkg::TargetReset;
      ecount_q <= '0;
      rd_q <= '0; wr_q <= '0; cnt_q <= '0; clr_q <= '0;
    end else begin
      if (cfg_we_i) target_q <= cfg_data_i;
      unique case (state_q)
        S_INIT: begin
          if (32'(clr_q) == 32'(NODES - 1)) state_q <= S_IDLE;
          clr_q <= clr_q + NW'(1);
        end
        S_IDLE: if (req.valid) begin
          if (req.req_type == fspe_pkg::ReqRun) begin
            lim_q <= req.age_limit;
            clr_q <= '0;
            state_q <= S_CLEAR;
          end else if (load_ok) begin
            ecount_q <= ecount_inc;
            src_q <= src_idx;
            state_q <= S_LOAD;
          end
        end
        S_LOAD: state_q <= S_IDLE;
        S_CLEAR: begin
          if (32'(clr_q) == 32'(NODES - 1)) begin
            rd_q <= '0;
            wr_q <= NW'(1 % NODES);
            cnt_q <= CW'(1);
            state_q <= S_QRD;
          end
          clr_q <= clr_q + NW'(1);
        end
        S_QRD: state_q <= S_POP;
        S_POP: begin
          if (cnt_q == '0) state_q <= S_TREAD;
          else begin
            x_q <= q_rd;
            rd_q <= (32'(rd_q) == 32'(NODES - 1)) ? '0 : rd_q + NW'(1);
            cnt_q <= cnt_q - CW'(1);
            state_q <= S_HEAD;
          end
        end
        S_HEAD: begin
          dx_q <= dist_rd;
          e_q <= head_rd_q;
          state_q <= (head_rd_q != '0) ? S_EREAD : S_QRD;
        end
        S_EREAD: state_q <= S_EVAL;
        S_EVAL: begin
          cand_q <= sat;
          state_q <= S_UPD;
        end
        S_UPD: begin
          if (push_ok) begin
            wr_q <= (32'(wr_q) == 32'(NODES - 1)) ? '0 : wr_q + NW'(1);
            cnt_q <= cnt_q + CW'(1);
          end
          e_q <= nx_rd;
          state_q <= (nx_rd != '0) ? S_EREAD : S_QRD;
        end
        S_TREAD: state_q <= S_TOUT;
        S_TOUT: begin
          res_q <= tgt_ok ? dist_rd : fspe_pkg::InfDist;
          state_q <= S_OUT;
        end
        S_OUT: if (res.ready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Assertions
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= 32'(NODES)) else $error("queue count overflow");
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res.valid && res.ready) |=> !res.valid) else $error("result repeated");
  a_ecount: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ecount_q) <= 32'(EDGES)) else $error("edge count overflow");
endmodule
